/* rtl/assert_macros.svh */
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// implication from one cycle to the next
`define ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("assertion failed");

`endif

/* rtl/i2cm_pkg.sv */
`default_nettype none

package i2cm_pkg;

    typedef enum logic [3:0] {
        CMD_NONE   = 4'd0,
        CMD_START  = 4'd1,
        CMD_STOP   = 4'd2,
        CMD_WRITE  = 4'd3,
        CMD_READ   = 4'd4,
        CMD_ACK    = 4'd5,
        CMD_NACK   = 4'd6,
        CMD_WAIT   = 4'd7,
        CMD_SAMPLE = 4'd8
    } cmd_t;

    localparam logic REG_HALF_PERIOD = 1'b0;
    localparam logic REG_ACK_LIMIT   = 1'b1;

    localparam logic [15:0] HALF_PERIOD_RESET = 16'd100;
    localparam logic [7:0]  ACK_LIMIT_RESET   = 8'd250;

    localparam logic [1:0] STEP_FIRST = 2'd0;
    localparam logic [1:0] STEP_SECOND = 2'd1;
    localparam logic [1:0] STEP_THIRD = 2'd2;
    localparam logic [2:0] LAST_BIT = 3'd7;

    typedef struct packed {
        cmd_t        cmd;
        logic [1:0]  step;
        logic [15:0] phase;
        logic [2:0]  bits;
        logic [7:0]  shreg;
        logic [7:0]  ack_cnt;
        logic        scl;
        logic        sda;
        logic        drive;
        logic [7:0]  rx;
        logic        ack;
        logic        tmo;
    } state_t;

    typedef struct packed {
        logic        rej;
        logic        tmo;
        logic        ack;
        logic [7:0]  rx;
        logic        done;
        logic        busy;
        logic        drive;
        logic        sda;
        logic        scl;
    } result_t;

    // pin levels for the current step of the current command
    function automatic state_t set_levels(state_t s, logic sample);
        state_t n;
        n = s;
        case (s.cmd)
            CMD_START:
            begin
                if (s.step == STEP_FIRST)
                begin
                    n.drive = 1'b1;
                    n.scl   = 1'b1;
                    n.sda   = 1'b1;
                end
                else
                begin
                    n.sda = 1'b0;
                end
            end
            CMD_STOP:
            begin
                if (s.step == STEP_FIRST)
                begin
                    n.drive = 1'b1;
                    n.scl   = 1'b0;
                    n.sda   = 1'b0;
                end
                else if (s.step == STEP_SECOND)
                begin
                    n.scl = 1'b1;
                end
                else
                begin
                    n.sda = 1'b1;
                end
            end
            CMD_WRITE:
            begin
                if (s.step == STEP_FIRST)
                begin
                    n.drive = 1'b1;
                    n.scl   = 1'b0;
                    n.sda   = s.shreg[7];
                end
                else if (s.step == STEP_SECOND)
                begin
                    n.scl = 1'b1;
                end
                else
                begin
                    n.scl = 1'b0;
                end
            end
            CMD_READ:
            begin
                if (s.step == STEP_FIRST)
                begin
                    n.drive = 1'b0;
                    n.sda   = 1'b1;
                    n.scl   = 1'b0;
                end
                else
                begin
                    n.scl   = 1'b1;
                    n.shreg = {s.shreg[6:0], sample};
                end
            end
            CMD_ACK, CMD_NACK:
            begin
                if (s.step == STEP_FIRST)
                begin
                    n.scl   = 1'b0;
                    n.drive = 1'b1;
                    n.sda   = (s.cmd == CMD_NACK);
                end
                else
                begin
                    n.scl = 1'b1;
                end
            end
            CMD_WAIT:
            begin
                if (s.step == STEP_FIRST)
                begin
                    n.drive = 1'b1;
                    n.sda   = 1'b1;
                end
                else if (s.step == STEP_SECOND)
                begin
                    n.scl = 1'b1;
                end
                else
                begin
                    n.drive = 1'b0;
                end
            end
            CMD_SAMPLE:
            begin
                if (s.step == STEP_FIRST)
                begin
                    n.drive = 1'b0;
                    n.sda   = 1'b1;
                end
                else
                begin
                    n.scl = 1'b1;
                end
            end
            default:
            begin
                n = s;
            end
        endcase
        return n;
    endfunction

endpackage

`default_nettype wire

/* rtl/i2cm_step.sv */
`default_nettype none

module i2cm_step (
    input  i2cm_pkg::state_t  cur,
    input  logic [15:0]       half_period,
    input  logic [7:0]        ack_limit,
    input  logic [3:0]        mode,
    input  logic [7:0]        tx_byte,
    input  logic              sda_sample,
    output i2cm_pkg::state_t  nxt,
    output i2cm_pkg::result_t res
);
    import i2cm_pkg::*;

    logic        done;
    logic        rej;
    logic        poll;
    logic [1:0]  last_step;
    logic [15:0] phase_inc;
    state_t      n;

    // next state for one tick
    always_comb
    begin
        n         = cur;
        done      = 1'b0;
        rej       = 1'b0;
        poll      = 1'b0;
        phase_inc = cur.phase + 16'd1;
        last_step = ((cur.cmd == CMD_STOP) || (cur.cmd == CMD_WRITE) || (cur.cmd == CMD_WAIT))
                    ? STEP_THIRD : STEP_SECOND;
        if (cur.cmd == CMD_NONE)
        begin
            if (mode inside {[CMD_START:CMD_SAMPLE]})
            begin
                n.cmd     = cmd_t'(mode);
                n.step    = STEP_FIRST;
                n.phase   = '0;
                n.bits    = '0;
                n.ack_cnt = '0;
                n.tmo     = 1'b0;
                n.shreg   = (mode == CMD_WRITE) ? tx_byte : 8'd0;
                n         = set_levels(n, sda_sample);
            end
        end
        else
        begin
            rej = (mode != CMD_NONE);
            if ((cur.cmd == CMD_WAIT) && (cur.step == STEP_THIRD))
            begin
                poll = 1'b1;
            end
            else
            begin
                n.phase = phase_inc;
                if (phase_inc >= half_period)
                begin
                    n.phase = '0;
                    if (cur.step < last_step)
                    begin
                        n.step = cur.step + 2'd1;
                        n      = set_levels(n, sda_sample);
                        if ((cur.cmd == CMD_WAIT) && (n.step == STEP_THIRD))
                        begin
                            poll = 1'b1;
                        end
                    end
                    else if (((cur.cmd == CMD_WRITE) || (cur.cmd == CMD_READ))
                             && (cur.bits < LAST_BIT))
                    begin
                        n.bits = cur.bits + 3'd1;
                        if (cur.cmd == CMD_WRITE)
                        begin
                            n.shreg = {cur.shreg[6:0], 1'b0};
                        end
                        n.step = STEP_FIRST;
                        n      = set_levels(n, sda_sample);
                    end
                    else
                    begin
                        case (cur.cmd)
                            CMD_START, CMD_ACK, CMD_NACK: n.scl = 1'b0;
                            CMD_READ:                     n.rx  = cur.shreg;
                            CMD_SAMPLE:
                            begin
                                n.ack = sda_sample;
                                n.scl = 1'b0;
                            end
                            default:                      n.scl = n.scl;
                        endcase
                        n.cmd   = CMD_NONE;
                        n.step  = STEP_FIRST;
                        n.phase = '0;
                        done    = 1'b1;
                    end
                end
            end
            // acknowledge poll: low ends the command, timeout falls into a stop
            if (poll)
            begin
                if (!sda_sample)
                begin
                    n.ack   = 1'b0;
                    n.scl   = 1'b0;
                    n.cmd   = CMD_NONE;
                    n.step  = STEP_FIRST;
                    n.phase = '0;
                    done    = 1'b1;
                end
                else if (n.ack_cnt >= ack_limit)
                begin
                    n.ack   = 1'b1;
                    n.tmo   = 1'b1;
                    n.cmd   = CMD_STOP;
                    n.step  = STEP_FIRST;
                    n.phase = '0;
                    n       = set_levels(n, sda_sample);
                end
                else
                begin
                    n.ack_cnt = n.ack_cnt + 8'd1;
                end
            end
        end
    end

    assign nxt = n;

    // result fields
    always_comb
    begin
        res.scl   = n.scl;
        res.sda   = n.sda;
        res.drive = n.drive;
        res.busy  = (n.cmd != CMD_NONE);
        res.done  = done;
        res.rx    = n.rx;
        res.ack   = n.ack;
        res.tmo   = n.tmo;
        res.rej   = rej;
    end

endmodule

`default_nettype wire

/* rtl/i2c_master_bit_engine.sv */
// i2c master bit engine
// each request on the s_ side is one tick: a command code, the byte to send
// and the level sensed on sda; each tick gives exactly one result on the m_
// side with the pin levels to drive, busy, done, the received byte, the
// acknowledge bit, the sticky timeout flag and the rejected flag
// a command is taken only while idle; a nonzero code while busy is dropped
// and flagged; codes above sample-ack while idle are ignored silently
// config channel: index 0 sets ticks per scl phase, index 1 the number of
// high sda samples tolerated while waiting for acknowledge; write only idle
// latency: the result of a tick appears one cycle after its request is taken
// throughput: one tick per cycle; the step logic is a single pass between
// the state register and the output register
// stall: the output register holds its result while m_tready is low and
// s_tready drops only when that register is full and not being drained
// reset: bus idle (scl, sda high and driven), no command, config registers
// back to 100 ticks and a limit of 250, no result pending
`default_nettype none

module i2c_master_bit_engine (
    input  logic        clk,
    input  logic        rst_n,
    // tick in: [3:0] mode, [11:4] tx_byte, [12] sda_sample, [15:13] zero
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,
    // result out: [0] scl_level, [1] sda_level, [2] sda_drive, [3] busy_res,
    // [4] done_res, [12:5] rx_byte, [13] ack_bit, [14] timed_out, [15] rejected
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,
    // config write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);
    import i2cm_pkg::*;

    state_t      state_reg;
    state_t      state_next;
    result_t     res;
    logic [15:0] half_period_reg;
    logic [7:0]  ack_limit_reg;
    logic [15:0] out_data_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        in_take;

    // config is always accepted
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_period_reg <= HALF_PERIOD_RESET;
            ack_limit_reg   <= ACK_LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_HALF_PERIOD: half_period_reg <= cfg_data;
                REG_ACK_LIMIT:   ack_limit_reg   <= cfg_data[7:0];
                default:         half_period_reg <= half_period_reg;
            endcase
        end
    end

    // input taken whenever the output slot is empty or draining
    assign s_tready = !out_valid_reg || m_tready;
    assign in_take  = s_tvalid && s_tready;

    i2cm_step u_step (
        .cur         (state_reg),
        .half_period (half_period_reg),
        .ack_limit   (ack_limit_reg),
        .mode        (s_tdata[3:0]),
        .tx_byte     (s_tdata[11:4]),
        .sda_sample  (s_tdata[12]),
        .nxt         (state_next),
        .res         (res)
    );

    // engine state, bus idle at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '{cmd: CMD_NONE, step: STEP_FIRST, phase: '0, bits: '0,
                           shreg: '0, ack_cnt: '0, scl: 1'b1, sda: 1'b1, drive: 1'b1,
                           rx: '0, ack: 1'b0, tmo: 1'b0};
        end
        else if (in_take)
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        if (in_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload, loaded on each taken tick
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            out_data_reg <= {res.rej, res.tmo, res.ack, res.rx, res.done,
                             res.busy, res.drive, res.sda, res.scl};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

/* rtl/i2cm_checker.sv */
`default_nettype none
`include "assert_macros.svh"

module i2cm_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata
);

    // a held result keeps its valid and payload
    `ASSERT_NEXT(a_out_hold_valid, clk, rst_n, m_tvalid && !m_tready, m_tvalid)
    `ASSERT_NEXT(a_out_hold_data, clk, rst_n, m_tvalid && !m_tready, $stable(m_tdata))
    // an empty output slot never blocks the input
    `ASSERT_CLK(a_ready_when_empty, clk, rst_n, !m_tvalid |-> s_tready)
    // every taken tick gives a result on the next cycle
    `ASSERT_NEXT(a_tick_gives_result, clk, rst_n, s_tvalid && s_tready, m_tvalid)
    // a completing command leaves the engine idle
    `ASSERT_CLK(a_done_not_busy, clk, rst_n, (m_tvalid && m_tdata[4]) |-> !m_tdata[3])

endmodule

bind i2c_master_bit_engine i2cm_checker u_i2cm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

/* test/testbench.sv */
`timescale 1ns / 100ps

module testbench;

    import i2cm_pkg::*;

    localparam int unsigned CYCLE_LIMIT     = 2_000_000;
    localparam int unsigned HOLD_OFF_CYCLES = 400;
    localparam int unsigned TAIL_CYCLES     = 10;
    localparam int unsigned RANDOM_TICKS    = 40;     // per idling phase, four phases

    // sda policies for a command: random level, or high until a given tick
    localparam int SDA_RANDOM     = -1;
    localparam int SDA_ALWAYS_LOW = 0;
    localparam int SDA_NEVER_LOW  = 32'h7fff_ffff;

    // codes past sample-ack, ignored by an idle engine
    localparam logic [3:0] MODE_UNKNOWN_LO = 4'd9;
    localparam logic [3:0] MODE_UNKNOWN_HI = 4'd15;

    // pin and status word of one tick, as carried on m_tdata
    typedef struct packed {
        logic       scl;
        logic       sda;
        logic       drive;
        logic       busy;
        logic       done;
        logic [7:0] rx;
        logic       ack;
        logic       tmo;
        logic       rej;
    } pin_state_t;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    // [3:0] mode, [11:4] tx_byte, [12] sda_sample, [15:13] zero
    logic [15:0] s_tdata   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    // [0] scl_level, [1] sda_level, [2] sda_drive, [3] busy_res, [4] done_res,
    // [12:5] rx_byte, [13] ack_bit, [14] timed_out, [15] rejected
    logic [15:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = REG_HALF_PERIOD;
    logic [15:0] cfg_data  = '0;

    i2c_master_bit_engine uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // engine state mirrored by the predictor
    cmd_t        bus_cmd;
    logic [1:0]  bus_step;
    logic [15:0] phase_cnt;
    logic [3:0]  bit_cnt;
    logic [7:0]  shifter;
    logic [7:0]  ack_polls;
    logic        scl_q;
    logic        sda_q;
    logic        drive_q;
    logic [7:0]  rx_q;
    logic        ack_q;
    logic        tmo_q;
    logic        done_pulse;
    logic [15:0] half_period;
    logic [7:0]  ack_limit;

    pin_state_t  pending_pins[$];
    pin_state_t  want_pins;

    int unsigned cycle_count     = 0;
    int unsigned mismatches      = 0;
    int unsigned ticks_sent      = 0;
    int unsigned ticks_effective = 0;
    int unsigned commands_taken  = 0;
    int unsigned rejections      = 0;
    int unsigned ack_timeouts    = 0;
    int unsigned src_idle_pct    = 0;
    int unsigned sink_stall_pct  = 0;
    int unsigned hold_off_asked  = 0;
    int unsigned hold_off_served = 0;
    int unsigned stall_left      = 0;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // predictor: one call per accepted tick
    // ------------------------------------------------------------------

    function automatic void reset_engine_model();
        half_period = HALF_PERIOD_RESET;
        ack_limit   = ACK_LIMIT_RESET;
        bus_cmd     = CMD_NONE;
        bus_step    = STEP_FIRST;
        phase_cnt   = '0;
        bit_cnt     = '0;
        shifter     = '0;
        ack_polls   = '0;
        scl_q       = 1'b1;
        sda_q       = 1'b1;
        drive_q     = 1'b1;
        rx_q        = '0;
        ack_q       = 1'b0;
        tmo_q       = 1'b0;
        done_pulse  = 1'b0;
    endfunction

    // pin levels held during the current step
    function automatic void apply_levels(logic sample);
        case (bus_cmd)
            CMD_START:
            begin
                if (bus_step == STEP_FIRST)
                begin
                    drive_q = 1'b1;
                    scl_q   = 1'b1;
                    sda_q   = 1'b1;
                end
                else
                    sda_q = 1'b0;
            end
            CMD_STOP:
            begin
                if (bus_step == STEP_FIRST)
                begin
                    drive_q = 1'b1;
                    scl_q   = 1'b0;
                    sda_q   = 1'b0;
                end
                else if (bus_step == STEP_SECOND)
                    scl_q = 1'b1;
                else
                    sda_q = 1'b1;
            end
            CMD_WRITE:
            begin
                if (bus_step == STEP_FIRST)
                begin
                    drive_q = 1'b1;
                    scl_q   = 1'b0;
                    sda_q   = shifter[7];
                end
                else if (bus_step == STEP_SECOND)
                    scl_q = 1'b1;
                else
                    scl_q = 1'b0;
            end
            CMD_READ:
            begin
                if (bus_step == STEP_FIRST)
                begin
                    drive_q = 1'b0;
                    sda_q   = 1'b1;
                    scl_q   = 1'b0;
                end
                else
                begin
                    // bit taken on the tick scl rises
                    scl_q   = 1'b1;
                    shifter = {shifter[6:0], sample};
                end
            end
            CMD_ACK, CMD_NACK:
            begin
                if (bus_step == STEP_FIRST)
                begin
                    scl_q   = 1'b0;
                    drive_q = 1'b1;
                    sda_q   = (bus_cmd == CMD_NACK);
                end
                else
                    scl_q = 1'b1;
            end
            CMD_WAIT:
            begin
                if (bus_step == STEP_FIRST)
                begin
                    drive_q = 1'b1;
                    sda_q   = 1'b1;
                end
                else if (bus_step == STEP_SECOND)
                    scl_q = 1'b1;
                else
                    drive_q = 1'b0;
            end
            CMD_SAMPLE:
            begin
                if (bus_step == STEP_FIRST)
                begin
                    drive_q = 1'b0;
                    sda_q   = 1'b1;
                end
                else
                    scl_q = 1'b1;
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic void complete_command(logic sample);
        case (bus_cmd)
            CMD_START, CMD_ACK, CMD_NACK:
                scl_q = 1'b0;
            // read leaves scl high, the last bit ends on it
            CMD_READ:
                rx_q = shifter;
            CMD_SAMPLE:
            begin
                ack_q = sample;
                scl_q = 1'b0;
            end
            default:
            begin
            end
        endcase
        bus_cmd    = CMD_NONE;
        bus_step   = STEP_FIRST;
        phase_cnt  = '0;
        done_pulse = 1'b1;
    endfunction

    // sda polled every tick once released; too many high polls turn into a stop
    function automatic void poll_for_ack(logic sample);
        if (!sample)
        begin
            ack_q      = 1'b0;
            scl_q      = 1'b0;
            bus_cmd    = CMD_NONE;
            bus_step   = STEP_FIRST;
            phase_cnt  = '0;
            done_pulse = 1'b1;
        end
        else if (ack_polls >= ack_limit)
        begin
            ack_q     = 1'b1;
            tmo_q     = 1'b1;
            bus_cmd   = CMD_STOP;
            bus_step  = STEP_FIRST;
            phase_cnt = '0;
            apply_levels(sample);
        end
        else
            ack_polls = ack_polls + 8'd1;
    endfunction

    function automatic void advance_step(logic sample);
        cmd_t       cmd;
        logic [1:0] last_step;
        cmd       = bus_cmd;
        last_step = (cmd == CMD_STOP || cmd == CMD_WRITE || cmd == CMD_WAIT) ?
                    STEP_THIRD : STEP_SECOND;
        if (bus_step < last_step)
        begin
            bus_step = bus_step + 2'd1;
            apply_levels(sample);
            if (cmd == CMD_WAIT && bus_step == STEP_THIRD)
                poll_for_ack(sample);
        end
        else if ((cmd == CMD_WRITE || cmd == CMD_READ) && bit_cnt < LAST_BIT)
        begin
            bit_cnt = bit_cnt + 4'd1;
            if (cmd == CMD_WRITE)
                shifter = shifter << 1;
            bus_step = STEP_FIRST;
            apply_levels(sample);
        end
        else
            complete_command(sample);
    endfunction

    function automatic pin_state_t engine_tick(logic [3:0] mode, logic [7:0] tx, logic sample);
        pin_state_t r;
        logic       rej;
        rej        = 1'b0;
        done_pulse = 1'b0;
        if (bus_cmd == CMD_NONE)
        begin
            if (mode >= CMD_START && mode <= CMD_SAMPLE)
            begin
                bus_cmd   = cmd_t'(mode);
                bus_step  = STEP_FIRST;
                phase_cnt = '0;
                bit_cnt   = '0;
                ack_polls = '0;
                tmo_q     = 1'b0;
                shifter   = (bus_cmd == CMD_WRITE) ? tx : 8'd0;
                apply_levels(sample);
            end
        end
        else
        begin
            // busy: any command code is dropped, even on the completing tick
            if (mode != CMD_NONE)
                rej = 1'b1;
            if (bus_cmd == CMD_WAIT && bus_step == STEP_THIRD)
                poll_for_ack(sample);
            else
            begin
                // a half period of zero behaves as one
                phase_cnt = phase_cnt + 16'd1;
                if (phase_cnt >= half_period)
                begin
                    phase_cnt = '0;
                    advance_step(sample);
                end
            end
        end
        r.scl   = scl_q;
        r.sda   = sda_q;
        r.drive = drive_q;
        r.busy  = (bus_cmd != CMD_NONE);
        r.done  = done_pulse;
        r.rx    = rx_q;
        r.ack   = ack_q;
        r.tmo   = tmo_q;
        r.rej   = rej;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // receiver side: random stalls plus the long hold-off on request
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[i2c_master_bit_engine] ERROR");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (hold_off_asked != hold_off_served)
        begin
            stall_left      = HOLD_OFF_CYCLES;
            hold_off_served = hold_off_asked;
        end
        if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    function automatic void compare_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // each result against the oldest predicted tick
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_pins.size() == 0)
            begin
                $error("result word with no tick pending: %h", m_tdata);
                mismatches++;
            end
            else
            begin
                want_pins = pending_pins.pop_front();
                compare_field("scl_level", want_pins.scl,   m_tdata[0]);
                compare_field("sda_level", want_pins.sda,   m_tdata[1]);
                compare_field("sda_drive", want_pins.drive, m_tdata[2]);
                compare_field("busy_res",  want_pins.busy,  m_tdata[3]);
                compare_field("done_res",  want_pins.done,  m_tdata[4]);
                compare_field("rx_byte",   want_pins.rx,    m_tdata[12:5]);
                compare_field("ack_bit",   want_pins.ack,   m_tdata[13]);
                compare_field("timed_out", want_pins.tmo,   m_tdata[14]);
                compare_field("rejected",  want_pins.rej,   m_tdata[15]);
            end
        end
    end

    // ------------------------------------------------------------------
    // sender side
    // ------------------------------------------------------------------

    // one tick request, with random idle cycles in front of it
    task automatic send_tick(input logic [3:0] mode, input logic [7:0] tx, input logic sample);
        pin_state_t r;
        logic       tmo_before;
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, sample, tx, mode};
        do
            @(posedge clk);
        while (!s_tready);
        if (bus_cmd != CMD_NONE || (mode >= CMD_START && mode <= CMD_SAMPLE))
            ticks_effective++;
        if (bus_cmd == CMD_NONE && mode >= CMD_START && mode <= CMD_SAMPLE)
            commands_taken++;
        tmo_before = tmo_q;
        r = engine_tick(mode, tx, sample);
        if (r.rej)
            rejections++;
        if (!tmo_before && r.tmo)
            ack_timeouts++;
        pending_pins.push_back(r);
        ticks_sent++;
    endtask

    function automatic logic pick_sda(int low_after, int idx);
        if (low_after < 0)
            return 1'($urandom_range(1));
        return (idx < low_after);
    endfunction

    // feed ticks until the running command is over, some carrying stray codes
    task automatic run_to_idle(input int low_after, input int unsigned reject_pct, input int first_idx);
        int         idx;
        logic [3:0] mode;
        idx = first_idx;
        while (bus_cmd != CMD_NONE)
        begin
            mode = ($urandom_range(99) < reject_pct) ? 4'($urandom_range(1, 15))
                                                      : 4'(CMD_NONE);
            send_tick(mode, 8'($urandom), pick_sda(low_after, idx));
            idx++;
        end
    endtask

    task automatic run_command(input logic [3:0] mode, input logic [7:0] tx,
                               input int low_after, input int unsigned reject_pct);
        send_tick(mode, tx, pick_sda(low_after, 0));
        run_to_idle(low_after, reject_pct, 1);
    endtask

    // finish the command, let every result drain, keep the bus quiet
    task automatic settle();
        run_to_idle(SDA_RANDOM, 0, 0);
        s_tvalid <= 1'b0;
        while (pending_pins.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_register(input logic index, input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (index == REG_HALF_PERIOD)
            half_period = value;
        else
            ack_limit = value[7:0];
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_idling(input int unsigned src_pct, input int unsigned sink_pct);
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
    endtask

    // ------------------------------------------------------------------
    // directed tests
    // ------------------------------------------------------------------

    // power-up values: 100 ticks per phase, 250 high polls before giving up
    task automatic test_reset_values();
        set_idling(0, 0);
        run_command(CMD_WAIT, 8'h00, SDA_NEVER_LOW, 0);
        settle();
    endtask

    task automatic test_command_set();
        set_idling(6, 6);
        write_register(REG_HALF_PERIOD, 16'd2);
        write_register(REG_ACK_LIMIT, 16'hff03);
        run_command(CMD_START, 8'h00, SDA_RANDOM, 0);
        run_command(CMD_WRITE, 8'h00, SDA_RANDOM, 0);
        run_command(CMD_WRITE, 8'hff, SDA_RANDOM, 0);
        run_command(CMD_WRITE, 8'h5a, SDA_RANDOM, 0);
        // acked after two high polls
        run_command(CMD_WAIT, 8'h00, 6, 0);
        run_command(CMD_READ, 8'h00, SDA_RANDOM, 0);
        run_command(CMD_READ, 8'hff, SDA_NEVER_LOW, 0);
        run_command(CMD_READ, 8'h00, SDA_ALWAYS_LOW, 0);
        run_command(CMD_ACK, 8'h00, SDA_RANDOM, 0);
        run_command(CMD_NACK, 8'h00, SDA_RANDOM, 0);
        run_command(CMD_SAMPLE, 8'h00, SDA_ALWAYS_LOW, 0);
        run_command(CMD_SAMPLE, 8'h00, SDA_NEVER_LOW, 0);
        run_command(CMD_STOP, 8'h00, SDA_RANDOM, 0);
        // codes past sample-ack do nothing while idle
        run_command(MODE_UNKNOWN_LO, 8'hff, SDA_NEVER_LOW, 0);
        run_command(MODE_UNKNOWN_HI, 8'hff, SDA_NEVER_LOW, 0);
        settle();
    endtask

    // every busy tick carries a command, the completing tick included
    task automatic test_busy_rejects();
        set_idling(0, 49);
        write_register(REG_HALF_PERIOD, 16'd1);
        write_register(REG_ACK_LIMIT, 16'd3);
        run_command(CMD_START, 8'h00, SDA_RANDOM, 100);
        // timeout, then the stop it issues, still rejecting
        run_command(CMD_WAIT, 8'h00, SDA_NEVER_LOW, 100);
        settle();
    endtask

    task automatic test_timing_extremes();
        set_idling(0, 0);
        // zero half period runs as one
        write_register(REG_HALF_PERIOD, 16'd0);
        run_command(CMD_WRITE, 8'hc3, SDA_RANDOM, 0);
        run_command(CMD_READ, 8'h00, SDA_RANDOM, 0);
        settle();
        write_register(REG_HALF_PERIOD, 16'd1);
        write_register(REG_ACK_LIMIT, 16'd255);
        run_command(CMD_WAIT, 8'h00, SDA_NEVER_LOW, 0);
        settle();
        write_register(REG_ACK_LIMIT, 16'h5a01);
        run_command(CMD_WAIT, 8'h00, SDA_NEVER_LOW, 0);
        settle();
    endtask

    // ------------------------------------------------------------------
    // random traffic
    // ------------------------------------------------------------------

    // wait-ack with a random point where the target pulls sda low, or a single sample
    task automatic random_ack_phase(input int unsigned reject_pct);
        if ($urandom_range(3) == 0)
            run_command(CMD_SAMPLE, 8'($urandom), SDA_RANDOM, reject_pct);
        else
            run_command(CMD_WAIT, 8'($urandom),
                        $urandom_range(0, 2 * half_period + ack_limit + 4), reject_pct);
    endtask

    // start, address, then data writes or reads, then stop
    task automatic random_transaction();
        int unsigned n;
        int unsigned k;
        n = $urandom_range(1, 3);
        run_command(CMD_START, 8'($urandom), SDA_RANDOM, 4);
        run_command(CMD_WRITE, 8'($urandom), SDA_RANDOM, 4);
        random_ack_phase(4);
        for (k = 0; k < n; k++)
        begin
            if ($urandom_range(1))
            begin
                run_command(CMD_WRITE, 8'($urandom), SDA_RANDOM, 4);
                random_ack_phase(4);
            end
            else
            begin
                run_command(CMD_READ, 8'($urandom), SDA_RANDOM, 4);
                run_command((k == n - 1) ? CMD_NACK : CMD_ACK, 8'($urandom), SDA_RANDOM, 4);
            end
        end
        run_command(CMD_STOP, 8'($urandom), SDA_RANDOM, 4);
    endtask

    // arbitrary codes, levels and bytes, then back to idle
    task automatic random_noise();
        repeat ($urandom_range(1, 8))
            send_tick(4'($urandom_range(15)), 8'($urandom), 1'($urandom_range(1)));
        run_to_idle(SDA_RANDOM, 20, 0);
    endtask

    task automatic test_random_traffic(input int unsigned src_pct, input int unsigned sink_pct,
                                       input bit with_hold_off);
        logic [15:0] limit_word;
        int unsigned start_count;
        bit          held;
        settle();
        limit_word      = 16'($urandom);
        limit_word[7:0] = ($urandom_range(3) == 0) ? 8'd1 : 8'($urandom_range(1, 12));
        write_register(REG_HALF_PERIOD, 16'($urandom_range(1, 2)));
        write_register(REG_ACK_LIMIT, limit_word);
        set_idling(src_pct, sink_pct);
        start_count = ticks_effective;
        held        = 1'b0;
        while (ticks_effective - start_count < RANDOM_TICKS)
        begin
            // receiver goes quiet while ticks keep coming, the block has to push back
            if (with_hold_off && !held)
            begin
                hold_off_asked++;
                held = 1'b1;
            end
            if ($urandom_range(99) < 80)
                random_transaction();
            else
                random_noise();
        end
        settle();
    endtask

    initial
    begin
        reset_engine_model();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_values();
        test_command_set();
        test_busy_rejects();
        test_timing_extremes();
        test_random_traffic(0, 0, 1'b1);
        test_random_traffic(49, 0, 1'b0);
        test_random_traffic(0, 49, 1'b0);
        test_random_traffic(6, 6, 1'b0);

        repeat (TAIL_CYCLES) @(posedge clk);
        $display("ticks sent: %0d (%0d driving the engine), commands started: %0d",
                 ticks_sent, ticks_effective, commands_taken);
        $display("busy rejections: %0d, acknowledge timeouts: %0d, mismatches: %0d",
                 rejections, ack_timeouts, mismatches);
        if (mismatches == 0 && pending_pins.size() == 0)
            $display("[i2c_master_bit_engine] OK");
        else
            $display("[i2c_master_bit_engine] ERROR");
        $finish;
    end

endmodule
